// ===== rtl/chacha20_stream_cipher_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef CHACHA20_STREAM_CIPHER_UNIT_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define CC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define CC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/ccsc_pkg.sv =====
package ccsc_pkg;

    localparam int unsigned NUM_CELLS = 8;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam logic [2:0] REG_KEY_Q0       = 3'd0;
    localparam logic [2:0] REG_KEY_Q1       = 3'd1;
    localparam logic [2:0] REG_KEY_Q2       = 3'd2;
    localparam logic [2:0] REG_KEY_Q3       = 3'd3;
    localparam logic [2:0] REG_NONCE_LOW    = 3'd4;
    localparam logic [2:0] REG_NONCE_HIGH   = 3'd5;
    localparam logic [2:0] REG_INIT_COUNTER = 3'd6;

    typedef logic [15:0][31:0] t_state;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    // One quarter round on four words.
    function automatic logic [127:0] quarter(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] ta, tb, tc, td;
        ta = a + b;  td = rotl(d ^ ta, 16);
        tc = c + td; tb = rotl(b ^ tc, 12);
        ta = ta + tb; td = rotl(td ^ ta, 8);
        tc = tc + td; tb = rotl(tb ^ tc, 7);
        quarter = {td, tc, tb, ta};
    endfunction

endpackage

// ===== rtl/ccsc_round_cell.sv =====
// One cell of the round chain: a single round (column or diagonal) per cycle.
module ccsc_round_cell #(
    parameter bit DIAGONAL = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ccsc_pkg::t_state i_work,
    input  ccsc_pkg::t_state i_init,
    output logic            o_valid,
    output ccsc_pkg::t_state o_work,
    output ccsc_pkg::t_state o_init
);
    import ccsc_pkg::*;

    t_state n_work;
    logic [127:0] q0, q1, q2, q3;

    // Quarter rounds on columns or diagonals.
    always_comb begin
        n_work = i_work;
        if (!DIAGONAL) begin
            q0 = quarter(i_work[0], i_work[4], i_work[8],  i_work[12]);
            q1 = quarter(i_work[1], i_work[5], i_work[9],  i_work[13]);
            q2 = quarter(i_work[2], i_work[6], i_work[10], i_work[14]);
            q3 = quarter(i_work[3], i_work[7], i_work[11], i_work[15]);
            {n_work[12], n_work[8],  n_work[4], n_work[0]} = q0;
            {n_work[13], n_work[9],  n_work[5], n_work[1]} = q1;
            {n_work[14], n_work[10], n_work[6], n_work[2]} = q2;
            {n_work[15], n_work[11], n_work[7], n_work[3]} = q3;
        end else begin
            q0 = quarter(i_work[0], i_work[5], i_work[10], i_work[15]);
            q1 = quarter(i_work[1], i_work[6], i_work[11], i_work[12]);
            q2 = quarter(i_work[2], i_work[7], i_work[8],  i_work[13]);
            q3 = quarter(i_work[3], i_work[4], i_work[9],  i_work[14]);
            {n_work[15], n_work[10], n_work[5], n_work[0]} = q0;
            {n_work[12], n_work[11], n_work[6], n_work[1]} = q1;
            {n_work[13], n_work[8],  n_work[7], n_work[2]} = q2;
            {n_work[14], n_work[9],  n_work[4], n_work[3]} = q3;
        end
    end

    logic   r_valid;
    t_state r_work, r_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_work <= n_work;
        r_init <= i_init;
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;
    assign o_init  = r_init;
endmodule

// ===== rtl/ccsc_round_chain.sv =====
// Chain of round cells followed by the final feed-forward add.
module ccsc_round_chain #(
    parameter int unsigned DOUBLE_ROUNDS = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ccsc_pkg::t_state i_init,
    output logic             o_valid,
    output ccsc_pkg::t_state o_block
);
    import ccsc_pkg::*;

    localparam int unsigned NR = 2 * DOUBLE_ROUNDS;

    logic   v  [NR+1];
    t_state wk [NR+1];
    t_state in [NR+1];

    assign v[0]  = i_valid;
    assign wk[0] = i_init;
    assign in[0] = i_init;

    for (genvar g = 0; g < NR; g++) begin : g_cell
        ccsc_round_cell #(.DIAGONAL(g % 2 == 1)) u_cell (
            .i_clk, .i_rst_n,
            .i_valid(v[g]), .i_work(wk[g]), .i_init(in[g]),
            .o_valid(v[g+1]), .o_work(wk[g+1]), .o_init(in[g+1])
        );
    end

    logic   r_valid;
    t_state r_block;

    // Add the initial state back in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= v[NR];
        end
        for (int k = 0; k < 16; k++) r_block[k] <= wk[NR][k] + in[NR][k];
    end

    assign o_valid = r_valid;
    assign o_block = r_block;
endmodule

// ===== rtl/chacha20_stream_cipher_unit.sv =====
// Channel | dir | handshake            | payload
// s_axis  | in  | tvalid/tready        | tdata{byte_count,text_in}, tlast=last
// m_axis  | out | tvalid/tready        | tdata{byte_count_out,text_out}, tlast, tuser
// cfg     | in  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// A word that starts a block waits for the round chain to produce the block, and no word
// is taken meanwhile; the other seven words of a block use the held keystream block.
// Reset is synchronous, active low; a stalled output holds in the output register
// and a new word is taken only when that register is free or being emptied.
module chacha20_stream_cipher_unit #(
    parameter int unsigned DOUBLE_ROUNDS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // text_in[63:0], byte_count[67:64], zero pad
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // text_out[63:0], byte_count_out[67:64], zero
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // counter_exhausted
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import ccsc_pkg::*;

    logic [63:0] r_key0, r_key1, r_key2, r_key3, r_nonce_lo;
    logic [31:0] r_nonce_hi, r_init_ctr, r_ctr;
    logic [2:0]  r_pos;
    logic        r_in_msg, r_wrapped, r_have_ks, r_busy;
    t_state      r_ks;

    logic        r_ovalid, r_olast, r_oexh;
    logic [63:0] r_odata;
    logic [3:0]  r_ocnt;

    assign o_cfg_ready = 1'b1;

    // Effective counter and position of the word at the input.
    logic [31:0] cur_ctr;
    logic [2:0]  cur_pos;
    logic        cur_wrap, need_block, out_free, can_take, acc;
    assign cur_ctr  = r_in_msg ? r_ctr : r_init_ctr;
    assign cur_pos  = r_in_msg ? r_pos : 3'd0;
    assign cur_wrap = r_in_msg && r_wrapped;
    assign need_block = !cur_wrap && cur_pos == 3'd0 && !r_have_ks;
    assign out_free = !r_ovalid || m_axis_tready;
    assign can_take = out_free && !r_busy && !need_block;
    assign s_axis_tready = can_take;
    assign acc = s_axis_tvalid && can_take;

    t_state init_st, blk;
    logic   blk_valid, start;
    assign start = s_axis_tvalid && need_block && !r_busy;
    always_comb begin
        init_st[0] = SIGMA0; init_st[1] = SIGMA1; init_st[2] = SIGMA2; init_st[3] = SIGMA3;
        init_st[4] = r_key0[31:0]; init_st[5] = r_key0[63:32];
        init_st[6] = r_key1[31:0]; init_st[7] = r_key1[63:32];
        init_st[8] = r_key2[31:0]; init_st[9] = r_key2[63:32];
        init_st[10] = r_key3[31:0]; init_st[11] = r_key3[63:32];
        init_st[12] = cur_ctr;
        init_st[13] = r_nonce_lo[31:0]; init_st[14] = r_nonce_lo[63:32];
        init_st[15] = r_nonce_hi;
    end

    ccsc_round_chain #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_chain (
        .i_clk, .i_rst_n, .i_valid(start), .i_init(init_st),
        .o_valid(blk_valid), .o_block(blk)
    );

    // Keystream slice and byte mask for the current word.
    logic [63:0] ks, mask;
    logic [3:0]  nb;
    assign ks = {r_ks[{cur_pos, 1'b1}], r_ks[{cur_pos, 1'b0}]};
    assign nb = s_axis_tdata[67] ? 4'd8 : s_axis_tdata[67:64];
    always_comb begin
        for (int b = 0; b < 8; b++) mask[b*8 +: 8] = (4'(b) < nb) ? 8'hFF : 8'h00;
    end

    logic [2:0] nxt_pos;
    assign nxt_pos = cur_pos + 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0; r_key1 <= '0; r_key2 <= '0; r_key3 <= '0;
            r_nonce_lo <= '0; r_nonce_hi <= '0; r_init_ctr <= 32'd1;
            r_ctr <= '0; r_pos <= '0; r_in_msg <= 1'b0; r_wrapped <= 1'b0;
            r_have_ks <= 1'b0; r_busy <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_KEY_Q0:       r_key0 <= i_cfg_data;
                    REG_KEY_Q1:       r_key1 <= i_cfg_data;
                    REG_KEY_Q2:       r_key2 <= i_cfg_data;
                    REG_KEY_Q3:       r_key3 <= i_cfg_data;
                    REG_NONCE_LOW:    r_nonce_lo <= i_cfg_data;
                    REG_NONCE_HIGH:   r_nonce_hi <= i_cfg_data[31:0];
                    REG_INIT_COUNTER: r_init_ctr <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (start) begin
                r_busy <= 1'b1;
            end else if (blk_valid) begin
                r_busy <= 1'b0;
            end
            // The held block stays usable only inside a message, up to its end or the block's last word.
            if (blk_valid) begin
                r_have_ks <= 1'b1;
            end else if (acc) begin
                r_have_ks <= !cur_wrap && cur_pos != 3'd7 && !s_axis_tlast;
            end
            if (acc) begin
                r_ovalid <= 1'b1;
            end else if (out_free) begin
                r_ovalid <= 1'b0;
            end
            if (acc) begin
                r_in_msg <= !s_axis_tlast;
                r_pos <= s_axis_tlast ? 3'd0 : nxt_pos;
                if (nxt_pos == 3'd0 && !cur_wrap) begin
                    r_ctr <= cur_ctr + 32'd1;
                    r_wrapped <= (cur_ctr == 32'hFFFFFFFF);
                end else begin
                    r_ctr <= cur_ctr;
                    r_wrapped <= cur_wrap;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (blk_valid) r_ks <= blk;
        if (acc) begin
            r_odata <= cur_wrap ? 64'd0 : ((s_axis_tdata[63:0] ^ ks) & mask);
            r_ocnt  <= s_axis_tdata[67:64];
            r_olast <= s_axis_tlast;
            r_oexh  <= cur_wrap;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_ocnt, r_odata};
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_oexh;
endmodule

// ===== rtl/ccsc_checker.sv =====
`include "chacha20_stream_cipher_unit_assert.svh"
// Port-level checks for the cipher unit.
module ccsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    `CC_ASSERT_IMP(a_exh_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[63:0] == 64'd0)
    `CC_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[71:68] == 4'd0)
    `CC_ASSERT_NEXT(a_out_after_in, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
    `CC_ASSERT_IMP(a_stall_blocks, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
endmodule

bind chacha20_stream_cipher_unit ccsc_checker u_ccsc_checker (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

// ===== tb/tb_chacha20_stream_cipher_unit.sv =====
`timescale 1ns / 100ps

module tb_chacha20_stream_cipher_unit;
    import ccsc_pkg::*;

    typedef struct packed {
        logic [63:0] text;
        logic [3:0]  count;
        logic        last;
    } t_word;

    typedef struct packed {
        logic [63:0] text;
        logic [3:0]  count;
        logic        last;
        logic        exhausted;
    } t_cipher_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    chacha20_stream_cipher_unit uut (.*);

    always #4 i_clk = ~i_clk;

    // Cipher predictor state: registers and the running position in the message.
    logic [63:0] key_reg [4];
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;
    logic [31:0] start_ctr_reg;
    logic [31:0] ks_block [16];
    logic [31:0] mix [16];
    logic [31:0] blk_ctr;
    logic [2:0]  word_pos;
    logic        msg_open;
    logic        ctr_spent;

    t_word        word_q [$];
    t_cipher_word cipher_q [$];
    int           errors = 0;
    int           words_out = 0;
    int           words_pushed = 0;
    int           spent_words = 0;
    int           msg_total = 0;
    bit           quiet = 1'b0;
    bit           in_fire = 1'b0;
    int           in_gap = 0;
    int           out_gap = 0;

    function automatic logic [31:0] rot32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function void mix_quarter(input int a, input int b, input int c, input int d);
        mix[a] = mix[a] + mix[b]; mix[d] = rot32(mix[d] ^ mix[a], 16);
        mix[c] = mix[c] + mix[d]; mix[b] = rot32(mix[b] ^ mix[c], 12);
        mix[a] = mix[a] + mix[b]; mix[d] = rot32(mix[d] ^ mix[a], 8);
        mix[c] = mix[c] + mix[d]; mix[b] = rot32(mix[b] ^ mix[c], 7);
    endfunction

    // Twenty rounds over the block state, then the feed-forward addition.
    function void build_keystream();
        logic [31:0] seed [16];
        seed[0] = 32'h61707865; seed[1] = 32'h3320646e;
        seed[2] = 32'h79622d32; seed[3] = 32'h6b206574;
        for (int i = 0; i < 4; i++) begin
            seed[4 + 2 * i] = key_reg[i][31:0];
            seed[5 + 2 * i] = key_reg[i][63:32];
        end
        seed[12] = blk_ctr;
        seed[13] = nonce_lo_reg[31:0];
        seed[14] = nonce_lo_reg[63:32];
        seed[15] = nonce_hi_reg;
        mix = seed;
        for (int r = 0; r < 10; r++) begin
            mix_quarter(0, 4, 8, 12); mix_quarter(1, 5, 9, 13);
            mix_quarter(2, 6, 10, 14); mix_quarter(3, 7, 11, 15);
            mix_quarter(0, 5, 10, 15); mix_quarter(1, 6, 11, 12);
            mix_quarter(2, 7, 8, 13); mix_quarter(3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++) ks_block[i] = mix[i] + seed[i];
    endfunction

    function t_cipher_word encrypt_word(input t_word w);
        t_cipher_word res;
        logic [63:0]  ks;
        logic [63:0]  mask;
        int           nbytes;
        nbytes = (w.count > 4'd8) ? 8 : int'(w.count);
        if (!msg_open) begin
            msg_open = 1'b1;
            blk_ctr = start_ctr_reg;
            word_pos = '0;
            ctr_spent = 1'b0;
        end
        res.text = '0;
        res.count = w.count;
        res.last = w.last;
        res.exhausted = ctr_spent;
        if (!ctr_spent) begin
            if (word_pos == 0) build_keystream();
            ks = {ks_block[2 * word_pos + 1], ks_block[2 * word_pos]};
            mask = (nbytes == 8) ? '1 : ((64'd1 << (8 * nbytes)) - 64'd1);
            res.text = (w.text ^ ks) & mask;
        end
        word_pos = word_pos + 3'd1;
        if (word_pos == 0 && !ctr_spent) begin
            if (blk_ctr == 32'hFFFF_FFFF) ctr_spent = 1'b1;
            blk_ctr = blk_ctr + 32'd1;
        end
        if (w.last) begin
            msg_open = 1'b0;
            word_pos = '0;
        end
        return res;
    endfunction

    // Input driver: takes the next word after each transfer, with random gaps.
    always @(negedge i_clk) begin
        t_word w;
        if (i_rst_n && (!s_axis_tvalid || in_fire)) begin
            if (in_gap > 0) begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (word_q.size() > 0) begin
                w = word_q.pop_front();
                s_axis_tdata <= {4'd0, w.count, w.text};
                s_axis_tlast <= w.last;
                s_axis_tvalid <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 15);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure in random bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 15);
        end
    end

    // Monitor: predict on each input transfer, check each output transfer.
    always @(posedge i_clk) begin
        t_word        w;
        t_cipher_word want;
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire) begin
            w.text = s_axis_tdata[63:0];
            w.count = s_axis_tdata[67:64];
            w.last = s_axis_tlast;
            cipher_q.push_back(encrypt_word(w));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            words_out++;
            if (m_axis_tuser) spent_words++;
            if (cipher_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected output word %h", $time, m_axis_tdata);
            end else begin
                want = cipher_q.pop_front();
                if (m_axis_tdata[63:0] !== want.text) begin
                    errors++;
                    $display("%0t: text expected %h actual %h", $time, want.text,
                             m_axis_tdata[63:0]);
                end
                if (m_axis_tdata[71:64] !== {4'd0, want.count}) begin
                    errors++;
                    $display("%0t: count expected %h actual %h", $time, want.count,
                             m_axis_tdata[71:64]);
                end
                if (m_axis_tlast !== want.last) begin
                    errors++;
                    $display("%0t: last expected %b actual %b", $time, want.last,
                             m_axis_tlast);
                end
                if (m_axis_tuser !== want.exhausted) begin
                    errors++;
                    $display("%0t: exhausted expected %b actual %b", $time,
                             want.exhausted, m_axis_tuser);
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_KEY_Q0: key_reg[0] = data;
            REG_KEY_Q1: key_reg[1] = data;
            REG_KEY_Q2: key_reg[2] = data;
            REG_KEY_Q3: key_reg[3] = data;
            REG_NONCE_LOW: nonce_lo_reg = data;
            REG_NONCE_HIGH: nonce_hi_reg = data[31:0];
            REG_INIT_COUNTER: start_ctr_reg = data[31:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every queued word has come out, then let the round chain settle.
    task automatic drain();
        @(negedge i_clk);
        while (words_out < words_pushed) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function void push_word(input logic [63:0] t, input logic [3:0] c, input logic l);
        t_word w;
        w.text = t; w.count = c; w.last = l;
        word_q.push_back(w);
        words_pushed++;
        if (l) msg_total++;
    endfunction

    // A message of n words: mostly well formed, sometimes with odd byte counts.
    function void push_message(input int n);
        logic [3:0] c;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) c = 4'($urandom_range(0, 15));
            else if (i == n - 1) c = 4'($urandom_range(1, 8));
            else c = 4'd8;
            push_word(rnd64(), c, i == n - 1);
        end
    endfunction

    task automatic random_config();
        logic [31:0] ctr;
        for (int r = 0; r < 6; r++)
            if ($urandom_range(0, 1) == 1) write_reg(r[2:0], rnd64());
        case ($urandom_range(0, 3))
            0: ctr = 32'hFFFF_FFFF;
            1: ctr = 32'hFFFF_FFFE;
            default: ctr = $urandom;
        endcase
        write_reg(REG_INIT_COUNTER, {32'd0, ctr});
    endtask

    initial begin
        int fed;
        key_reg = '{default: '0};
        nonce_lo_reg = '0;
        nonce_hi_reg = '0;
        start_ctr_reg = 32'd1;
        blk_ctr = '0;
        word_pos = '0;
        msg_open = 1'b0;
        ctr_spent = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset key and nonce: field extremes, zero and oversized counts, short middle word.
        push_word('0, 4'd8, 1'b0);
        push_word('1, 4'd8, 1'b0);
        push_word(rnd64(), 4'd0, 1'b0);
        push_word(rnd64(), 4'd15, 1'b0);
        push_word(rnd64(), 4'd9, 1'b0);
        push_word(rnd64(), 4'd3, 1'b0);
        push_word(rnd64(), 4'd8, 1'b0);
        push_word(rnd64(), 4'd8, 1'b0);
        push_word(rnd64(), 4'd5, 1'b1);
        push_word('1, 4'd1, 1'b1);
        drain();

        // Standard test key and nonce, counter 1.
        write_reg(REG_KEY_Q0, 64'h0706050403020100);
        write_reg(REG_KEY_Q1, 64'h0f0e0d0c0b0a0908);
        write_reg(REG_KEY_Q2, 64'h1716151413121110);
        write_reg(REG_KEY_Q3, 64'h1f1e1d1c1b1a1918);
        write_reg(REG_NONCE_LOW, 64'h4a00000009000000);
        write_reg(REG_NONCE_HIGH, 64'h0);
        write_reg(REG_INIT_COUNTER, 64'd1);
        push_word('0, 4'd8, 1'b0);
        push_word('0, 4'd8, 1'b1);
        drain();

        // Counter runs out after the first block; the next message starts over.
        write_reg(REG_INIT_COUNTER, 64'hFFFF_FFFF);
        for (int i = 0; i < 10; i++) push_word(rnd64(), 4'd8, i == 9);
        push_word(rnd64(), 4'd8, 1'b1);
        drain();

        // All-ones key and nonce, counter zero.
        for (int r = 0; r < 6; r++) write_reg(r[2:0], '1);
        write_reg(REG_INIT_COUNTER, 64'd0);
        push_message(3);
        drain();

        // Random phases, each under a new setting; the last runs without idling.
        for (int ph = 0; ph < 6; ph++) begin
            random_config();
            if (ph == 5) quiet = 1'b1;
            fed = 0;
            while (fed < 110) begin
                int n;
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
                push_message(n);
                fed += n;
            end
            drain();
        end

        $display("Covered %0d output words in %0d messages, %0d of them past counter end.",
                 words_out, msg_total, spent_words);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== chacha20_stream_cipher_unit.f =====
+incdir+rtl
rtl/ccsc_pkg.sv
rtl/ccsc_round_cell.sv
rtl/ccsc_round_chain.sv
rtl/chacha20_stream_cipher_unit.sv
rtl/ccsc_checker.sv
tb/tb_chacha20_stream_cipher_unit.sv
